// ===== sv/swlp_pkg.sv =====
// ----------------------------------------------------------------------------
// swlp_pkg
// Shared types, constants and the palette table for the waterfall line
// pixel generator.
// ----------------------------------------------------------------------------
package swlp_pkg;

    localparam int COL_W   = 12;
    localparam int MAG_W   = 8;
    localparam int CHAN_W  = 8;
    localparam int WIDTH_W = 13;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd1024;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX   = 13'd4096;
    localparam logic [MAG_W-1:0]   MIN_RESET   = 8'd255;

    typedef logic [3*CHAN_W-1:0] rgb_t;
    typedef rgb_t palette_lut_t [256];

    // One bin after the column has been worked out.
    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [MAG_W-1:0] magnitude;
        logic             last;
    } bin_item_t;

    // One finished pixel.
    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              line_end;
    } pixel_t;

    // Six-segment palette, evaluated at elaboration only.
    function automatic palette_lut_t build_palette();
        palette_lut_t lut;
        int r;
        int g;
        int b;
        for (int v = 0; v < 256; v++) begin
            if (v < 43) begin
                r = 0; g = 0; b = 255 * v / 43;
            end else if (v < 87) begin
                r = 0; g = 255 * (v - 43) / 43; b = 255;
            end else if (v < 120) begin
                r = 0; g = 255; b = 255 - 255 * (v - 87) / 32;
            end else if (v < 154) begin
                r = 255 * (v - 120) / 33; g = 255; b = 0;
            end else if (v < 217) begin
                r = 255; g = 255 - 255 * (v - 154) / 62; b = 0;
            end else begin
                r = 255; g = 0; b = 128 * (v - 217) / 38;
            end
            lut[v] = {CHAN_W'(r), CHAN_W'(g), CHAN_W'(b)};
        end
        return lut;
    endfunction

    localparam palette_lut_t PALETTE = build_palette();

endpackage

// ===== sv/swlp_front.sv =====
// ----------------------------------------------------------------------------
// swlp_front
// Accepts bins, counts them through the line and works out the pixel column
// of each bin with one multiply by the display width.
// ----------------------------------------------------------------------------
module swlp_front #(
    parameter int BINS_PER_LINE = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [swlp_pkg::WIDTH_W-1:0]       cfg_wr_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [swlp_pkg::MAG_W-1:0]         magnitude,
    input  logic                               q_full,
    output logic                               q_push,
    output swlp_pkg::bin_item_t                q_item
);

    localparam int BIN_W = $clog2(BINS_PER_LINE);
    localparam int PW    = BIN_W + swlp_pkg::WIDTH_W;
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(BINS_PER_LINE - 1);

    logic [swlp_pkg::WIDTH_W-1:0] width_reg;
    logic [swlp_pkg::WIDTH_W-1:0] width_used;
    logic [BIN_W-1:0]             bin_reg;
    logic [BIN_W-1:0]             bin_next;
    logic [PW-1:0]                product;
    logic                         adv;
    logic                         accept;
    logic                         is_last;

    logic                         vld_reg;
    logic [swlp_pkg::COL_W-1:0]   col_reg;
    logic [swlp_pkg::MAG_W-1:0]   mag_reg;
    logic                         last_reg;

    // The stage moves as a whole; the queue never overflows since a push
    // only happens while it has room.
    assign adv      = !q_full;
    assign in_stall = !adv;
    assign accept   = in_valid && adv;
    assign is_last  = (bin_reg == LAST_BIN);
    assign bin_next = is_last ? '0 : bin_reg + 1'b1;

    assign width_used = (width_reg > swlp_pkg::WIDTH_MAX) ? swlp_pkg::WIDTH_MAX : width_reg;

    // The line length is a power of two, so the column is the product
    // shifted down by the bin counter width.
    assign product = PW'(bin_reg) * PW'(width_used);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= swlp_pkg::WIDTH_RESET;
            bin_reg   <= '0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                width_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                bin_reg <= bin_next;
            end
            if (adv)
            begin
                vld_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            col_reg  <= swlp_pkg::COL_W'(product >> BIN_W);
            mag_reg  <= magnitude;
            last_reg <= is_last;
        end
    end

    assign q_push           = vld_reg && adv;
    assign q_item.column    = col_reg;
    assign q_item.magnitude = mag_reg;
    assign q_item.last      = last_reg;

endmodule

// ===== sv/swlp_queue.sv =====
// ----------------------------------------------------------------------------
// swlp_queue
// Short queue of column-tagged bins between the front and the back part.
// ----------------------------------------------------------------------------
module swlp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  swlp_pkg::bin_item_t push_item,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output swlp_pkg::bin_item_t head
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    swlp_pkg::bin_item_t mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                do_pop;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign do_pop = pop && !empty;
    assign head   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/swlp_back.sv =====
// ----------------------------------------------------------------------------
// swlp_back
// Keeps the open column and its minimum, emits finished columns through the
// palette and holds a second result when one bin yields two.
// ----------------------------------------------------------------------------
module swlp_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  swlp_pkg::bin_item_t          q_head,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output swlp_pkg::pixel_t             pixel
);

    logic [swlp_pkg::COL_W-1:0] cur_reg;
    logic [swlp_pkg::MAG_W-1:0] min_reg;
    logic [swlp_pkg::MAG_W-1:0] min_next;
    logic                       out_valid_reg;
    logic                       second_valid_reg;
    swlp_pkg::pixel_t           out_reg;
    swlp_pkg::pixel_t           second_reg;
    swlp_pkg::pixel_t           res_close;
    swlp_pkg::pixel_t           res_flush;
    logic                       out_free;
    logic                       advance;
    logic [swlp_pkg::MAG_W-1:0] merged;

    assign out_free = !out_valid_reg || !out_stall;
    assign q_pop    = !q_empty && !second_valid_reg && out_free;

    // A bin in a higher column closes the open one and starts a new minimum.
    assign advance  = (q_head.column > cur_reg);
    assign merged   = (q_head.magnitude < min_reg) ? q_head.magnitude : min_reg;
    assign min_next = advance ? q_head.magnitude : merged;

    assign res_close = {cur_reg, swlp_pkg::PALETTE[min_reg], 1'b0};
    assign res_flush = {advance ? q_head.column : cur_reg, swlp_pkg::PALETTE[min_next], 1'b1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg          <= '0;
            min_reg          <= swlp_pkg::MIN_RESET;
            out_valid_reg    <= 1'b0;
            second_valid_reg <= 1'b0;
        end
        else
        begin
            if (second_valid_reg && out_free)
            begin
                out_valid_reg    <= 1'b1;
                second_valid_reg <= 1'b0;
            end
            else if (q_pop)
            begin
                out_valid_reg    <= advance || q_head.last;
                second_valid_reg <= advance && q_head.last;
                cur_reg          <= q_head.last ? '0 : (advance ? q_head.column : cur_reg);
                min_reg          <= q_head.last ? swlp_pkg::MIN_RESET : min_next;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (second_valid_reg && out_free)
        begin
            out_reg <= second_reg;
        end
        else if (q_pop)
        begin
            out_reg    <= advance ? res_close : res_flush;
            second_reg <= res_flush;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel     = out_reg;

endmodule

// ===== sv/spectrum_waterfall_line_pixels.sv =====
// ----------------------------------------------------------------------------
// spectrum_waterfall_line_pixels
// Squeezes a line of spectrum bins into pixel columns, keeps each column's
// minimum and emits the column colored by a six-segment palette.
// ----------------------------------------------------------------------------
// The block takes one bin per clock while in_stall is low. Each bin is
// multiplied by the display width in one register stage, and since the line
// length is a power of two its column is the top bits of that product. A
// finishing bin passes the front stage register and the queue, then its pixel
// is loaded into the output register. Finished columns leave at one per clock
// while out_stall is low; the last bin of a line that also closes a column
// yields two pixels, which leave the output register one after the other and
// hold the column tracker meanwhile, absorbed by the four-entry queue. The
// display width takes effect for the next bin accepted after the write.
module spectrum_waterfall_line_pixels #(
    parameter int BINS_PER_LINE = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [swlp_pkg::WIDTH_W-1:0]   cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [swlp_pkg::MAG_W-1:0]     magnitude,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [swlp_pkg::COL_W-1:0]     column,
    output logic [swlp_pkg::CHAN_W-1:0]    red,
    output logic [swlp_pkg::CHAN_W-1:0]    green,
    output logic [swlp_pkg::CHAN_W-1:0]    blue,
    output logic                           line_end
);

    logic                q_full;
    logic                q_empty;
    logic                q_push;
    logic                q_pop;
    swlp_pkg::bin_item_t q_item;
    swlp_pkg::bin_item_t q_head;
    swlp_pkg::pixel_t    pixel;

    swlp_front #(
        .BINS_PER_LINE (BINS_PER_LINE)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .magnitude   (magnitude),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (q_item)
    );

    swlp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    swlp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel     (pixel)
    );

    assign column   = pixel.column;
    assign red      = pixel.red;
    assign green    = pixel.green;
    assign blue     = pixel.blue;
    assign line_end = pixel.line_end;

endmodule
